// ===== src/adpcm_pkg.sv =====
package adpcm_pkg;

    localparam logic [3:0] BLOCK_DATA_BYTES = 4'd14;
    localparam logic signed [31:0] SAT_HIGH = 32'sd32767;
    localparam logic signed [31:0] SAT_LOW  = -32'sd32767;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_FLAGS   = 2'd1,
        KIND_DATA    = 2'd2,
        KIND_RESTART = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        END_CONTINUE = 2'd0,
        END_JUMP     = 2'd1,
        END_STOP     = 2'd2
    } t_end;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ADD
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic hdr;
        logic flags;
        logic restart;
        logic latch;
        logic mul;
        logic commit;
        logic half;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_dp_stat;

    function automatic logic [7:0] coef_a(input logic [2:0] filter);
        logic [7:0] c;
        unique case (filter)
            3'd1:    c = 8'd60;
            3'd2:    c = 8'd115;
            3'd3:    c = 8'd98;
            3'd4:    c = 8'd122;
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    function automatic logic signed [6:0] coef_b(input logic [2:0] filter);
        logic signed [6:0] c;
        unique case (filter)
            3'd2:    c = -7'sd52;
            3'd3:    c = -7'sd55;
            3'd4:    c = -7'sd60;
            default: c = 7'sd0;
        endcase
        return c;
    endfunction

endpackage

// ===== src/adpcm_block_decoder.sv =====
// channel   direction  handshake                 payload
// in        input      i_in_valid / o_in_stall   i_kind, i_block_byte
// out       output     o_out_valid / i_out_stall o_sample, o_block_last,
//                                                o_loop_mark, o_end_action
// cfg       input      i_cfg_we                  i_cfg_data (output enable)
//
// header, flags and restart requests are taken in the idle state and leave it there
// a data byte is accepted, then multiply and accumulate run for each
// of its two samples through one shared predictor unit
// a stalled full output register holds either accumulate step until it drains
// reset (i_rst_n low, synchronous) clears history, block state and output enable
module adpcm_block_decoder
    import adpcm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_kind,
    input  logic [7:0]        i_block_byte,
    input  logic              i_cfg_we,
    input  logic              i_cfg_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic signed [15:0] o_sample,
    output logic              o_block_last,
    output logic              o_loop_mark,
    output logic [1:0]        o_end_action
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    adpcm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    adpcm_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_block_byte (i_block_byte),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_sample     (o_sample),
        .o_block_last (o_block_last),
        .o_loop_mark  (o_loop_mark),
        .o_end_action (o_end_action)
    );

endmodule

// ===== src/adpcm_ctrl.sv =====
module adpcm_ctrl
    import adpcm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic [1:0] i_kind,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_in_stall
);

    t_state r_state, n_state;
    logic   r_half, n_half;
    t_kind  w_kind;

    assign w_kind = t_kind'(i_kind);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_half  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_half  <= n_half;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_half     = r_half;
        o_cmd      = '0;
        o_cmd.half = r_half;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    unique case (w_kind)
                        KIND_HEADER:  o_cmd.hdr     = 1'b1;
                        KIND_FLAGS:   o_cmd.flags   = 1'b1;
                        KIND_RESTART: o_cmd.restart = 1'b1;
                        KIND_DATA: begin
                            o_cmd.latch = 1'b1;
                            n_half      = 1'b0;
                            n_state     = S_MUL;
                        end
                        default: ;
                    endcase
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                // hold the products until the output register can take the sample
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    if (r_half) begin
                        n_state = S_IDLE;
                    end else begin
                        n_half  = 1'b1;
                        n_state = S_MUL;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> i_stat.out_free)
        else $error("sample committed while output register busy");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.commit && r_half) |=> (r_state == S_IDLE))
        else $error("controller did not return to idle after second sample");

endmodule

// ===== src/adpcm_dp.sv =====
module adpcm_dp
    import adpcm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  logic [7:0]        i_block_byte,
    input  logic              i_cfg_we,
    input  logic              i_cfg_data,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic signed [15:0] o_sample,
    output logic              o_block_last,
    output logic              o_loop_mark,
    output logic [1:0]        o_end_action
);

    logic signed [31:0] r_hist1, r_hist2;
    logic [3:0]         r_shift;
    logic [2:0]         r_filter;
    logic [7:0]         r_flags;
    logic [3:0]         r_count;
    logic               r_out_en;
    logic               r_out_valid;
    logic [7:0]         r_byte;
    logic signed [31:0] r_p1, r_p2;
    logic signed [15:0] r_sample;
    logic               r_last, r_loop;
    t_end               r_end;

    logic [3:0]         w_nib;
    logic signed [31:0] w_nib_ext, w_sum;
    logic signed [15:0] w_sat;
    logic [3:0]         w_count_inc;
    logic               w_last;
    t_end               w_end;
    logic signed [6:0]  w_cb;

    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    assign w_nib       = i_cmd.half ? r_byte[7:4] : r_byte[3:0];
    assign w_nib_ext   = {{16{w_nib[3]}}, w_nib, 12'b0};
    assign w_sum       = (w_nib_ext >>> r_shift) + (r_p1 >>> 6) + (r_p2 >>> 6);
    assign w_count_inc = r_count + 4'd1;
    assign w_last      = i_cmd.half && (w_count_inc >= BLOCK_DATA_BYTES);
    assign w_cb        = coef_b(r_filter);

    always_comb begin
        if (!r_out_en) begin
            w_sat = 16'sd0;
        end else if (w_sum > SAT_HIGH) begin
            w_sat = SAT_HIGH[15:0];
        end else if (w_sum < SAT_LOW) begin
            w_sat = SAT_LOW[15:0];
        end else begin
            w_sat = w_sum[15:0];
        end
    end

    always_comb begin
        if (!r_flags[0]) begin
            w_end = END_CONTINUE;
        end else if (r_flags == 8'd3) begin
            w_end = END_JUMP;
        end else begin
            w_end = END_STOP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist1     <= '0;
            r_hist2     <= '0;
            r_shift     <= '0;
            r_filter    <= '0;
            r_flags     <= '0;
            r_count     <= '0;
            r_out_en    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_out_en <= i_cfg_data;
            end
            if (i_cmd.hdr) begin
                r_shift  <= i_block_byte[3:0];
                // predictor codes above four fall back to filter 0
                r_filter <= (i_block_byte[7:4] <= 4'd4) ? i_block_byte[6:4] : 3'd0;
                r_count  <= '0;
            end
            if (i_cmd.flags) begin
                r_flags <= i_block_byte;
            end
            if (i_cmd.restart) begin
                r_hist1 <= '0;
                r_hist2 <= '0;
                r_count <= '0;
            end
            if (i_cmd.commit) begin
                r_hist1 <= w_sum;
                r_hist2 <= r_hist1;
                if (i_cmd.half) begin
                    r_count <= w_last ? 4'd0 : w_count_inc;
                end
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_byte <= i_block_byte;
        end
        if (i_cmd.mul) begin
            // low 32 bits of each product, wrapping like the history
            r_p1 <= r_hist1 * $signed({24'b0, coef_a(r_filter)});
            r_p2 <= r_hist2 * $signed({{25{w_cb[6]}}, w_cb});
        end
        if (i_cmd.commit) begin
            r_sample <= w_sat;
            r_last   <= w_last;
            r_loop   <= w_last && r_flags[2];
            r_end    <= w_last ? w_end : END_CONTINUE;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample     = r_sample;
    assign o_block_last = r_last;
    assign o_loop_mark  = r_loop;
    assign o_end_action = r_end;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < BLOCK_DATA_BYTES)
        else $error("data byte count left the block range");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.commit))
        else $error("output valid without a committed sample");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_sample != 16'sh8000))
        else $error("sample outside saturation range");

endmodule

// ===== tb/tb_adpcm_block_decoder.sv =====
module tb_adpcm_block_decoder;
    import adpcm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 325;
    localparam int NUM_PHASES   = 5;

    typedef struct {
        logic signed [15:0] sample;
        logic               last;
        logic               loop_mark;
        t_end               act;
    } t_pcm_result;

    typedef struct {
        logic               cfg_before;
        logic               cfg_val;
        t_kind              kind;
        logic [7:0]         data;
        int                 reps;
        logic               typed;
        logic signed [15:0] lo_pcm;
        logic signed [15:0] hi_pcm;
    } t_dir_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_kind = 2'd0;
    logic [7:0]         i_block_byte = 8'd0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_data = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [15:0] o_sample;
    logic               o_block_last;
    logic               o_loop_mark;
    logic [1:0]         o_end_action;

    // decoder state as seen by the predictor
    logic signed [31:0] hist_one = '0;
    logic signed [31:0] hist_two = '0;
    logic [3:0]         shift_amt = '0;
    logic [2:0]         filt_sel = '0;
    logic [7:0]         blk_flags = '0;
    logic [3:0]         data_count = '0;
    logic               out_enable = 1'b0;

    t_pcm_result pending_pcm[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned items_sent = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int unsigned hold_reqs = 0;
    int unsigned holds_done = 0;

    t_dir_row dir_rows [0:17] = '{
        // output disabled right after reset
        '{1'b0, 1'b0, KIND_DATA,    8'h77, 1,  1'b1, 16'sd0,     16'sd0},
        '{1'b1, 1'b1, KIND_HEADER,  8'h0C, 1,  1'b0, 16'sd0,     16'sd0},
        '{1'b0, 1'b0, KIND_DATA,    8'h71, 1,  1'b1, 16'sd1,     16'sd7},
        '{1'b0, 1'b0, KIND_HEADER,  8'h00, 1,  1'b0, 16'sd0,     16'sd0},
        '{1'b0, 1'b0, KIND_DATA,    8'h87, 1,  1'b1, 16'sd28672, -16'sd32767},
        '{1'b0, 1'b0, KIND_HEADER,  8'h0F, 1,  1'b0, 16'sd0,     16'sd0},
        '{1'b0, 1'b0, KIND_DATA,    8'h78, 1,  1'b1, -16'sd1,    16'sd0},
        // predictor nibble above four falls back to no prediction
        '{1'b0, 1'b0, KIND_HEADER,  8'hF0, 1,  1'b0, 16'sd0,     16'sd0},
        '{1'b0, 1'b0, KIND_DATA,    8'h00, 1,  1'b1, 16'sd0,     16'sd0},
        '{1'b0, 1'b0, KIND_HEADER,  8'h4D, 1,  1'b0, 16'sd0,     16'sd0},
        '{1'b0, 1'b0, KIND_DATA,    8'h9F, 1,  1'b0, 16'sd0,     16'sd0},
        '{1'b0, 1'b0, KIND_HEADER,  8'h30, 1,  1'b0, 16'sd0,     16'sd0},
        '{1'b0, 1'b0, KIND_DATA,    8'h80, 1,  1'b0, 16'sd0,     16'sd0},
        // restart clears history, so a zero byte decodes to zero
        '{1'b0, 1'b0, KIND_RESTART, 8'hFF, 1,  1'b0, 16'sd0,     16'sd0},
        '{1'b0, 1'b0, KIND_DATA,    8'h00, 1,  1'b1, 16'sd0,     16'sd0},
        '{1'b0, 1'b0, KIND_FLAGS,   8'h03, 1,  1'b0, 16'sd0,     16'sd0},
        // finish the block, then run on past it without a header
        '{1'b0, 1'b0, KIND_DATA,    8'hA5, 13, 1'b0, 16'sd0,     16'sd0},
        '{1'b0, 1'b0, KIND_DATA,    8'h3E, 1,  1'b0, 16'sd0,     16'sd0}
    };

    int phase_idle  [NUM_PHASES] = '{0, 65, 0, 35, 0};
    int phase_stall [NUM_PHASES] = '{0, 0, 65, 35, 35};
    int phase_enable[NUM_PHASES] = '{1, 0, 1, 1, 1};

    adpcm_block_decoder dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic signed [31:0] decode_nibble_pcm(input logic [3:0] nib);
        logic signed [31:0] raw;
        logic signed [31:0] gain_a;
        logic signed [31:0] gain_b;
        logic signed [31:0] term_a;
        logic signed [31:0] term_b;
        logic signed [31:0] v;
        case (filt_sel)
            3'd1:    begin gain_a = 32'sd60;  gain_b = 32'sd0;   end
            3'd2:    begin gain_a = 32'sd115; gain_b = -32'sd52; end
            3'd3:    begin gain_a = 32'sd98;  gain_b = -32'sd55; end
            3'd4:    begin gain_a = 32'sd122; gain_b = -32'sd60; end
            default: begin gain_a = 32'sd0;   gain_b = 32'sd0;   end
        endcase
        raw = {{16{nib[3]}}, nib, 12'h000};
        raw = raw >>> shift_amt;
        // products wrap at 32 bits
        term_a = hist_one * gain_a;
        term_b = hist_two * gain_b;
        v = raw + (term_a >>> 6) + (term_b >>> 6);
        hist_two = hist_one;
        hist_one = v;
        return v;
    endfunction

    function automatic logic signed [15:0] clamp_pcm(input logic signed [31:0] v);
        if (!out_enable)
            return 16'sd0;
        if (v > 32'sd32767)
            return 16'sd32767;
        if (v < -32'sd32767)
            return -16'sd32767;
        return v[15:0];
    endfunction

    // advances the predicted state; returns 1 when the request yields two samples
    function automatic bit decode_request(input t_kind k, input logic [7:0] b,
                                          output t_pcm_result r0, output t_pcm_result r1);
        logic last;
        case (k)
            KIND_HEADER: begin
                shift_amt  = b[3:0];
                filt_sel   = (b[7:4] <= 4'd4) ? b[6:4] : 3'd0;
                data_count = '0;
                return 1'b0;
            end
            KIND_FLAGS: begin
                blk_flags = b;
                return 1'b0;
            end
            KIND_RESTART: begin
                hist_one   = '0;
                hist_two   = '0;
                data_count = '0;
                return 1'b0;
            end
            default: begin
                r0.sample = clamp_pcm(decode_nibble_pcm(b[3:0]));
                r1.sample = clamp_pcm(decode_nibble_pcm(b[7:4]));
                data_count = data_count + 4'd1;
                last = (data_count >= BLOCK_DATA_BYTES);
                if (last)
                    data_count = '0;
                r0.last      = 1'b0;
                r0.loop_mark = 1'b0;
                r0.act       = END_CONTINUE;
                r1.last      = last;
                r1.loop_mark = last & blk_flags[2];
                if (!last || !blk_flags[0])
                    r1.act = END_CONTINUE;
                else if (blk_flags == 8'h03)
                    r1.act = END_JUMP;
                else
                    r1.act = END_STOP;
                return 1'b1;
            end
        endcase
    endfunction

    task automatic issue_request(input t_kind k, input logic [7:0] b,
                                 input logic typed = 1'b0,
                                 input logic signed [15:0] lo_pcm = '0,
                                 input logic signed [15:0] hi_pcm = '0);
        t_pcm_result r0;
        t_pcm_result r1;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid   <= 1'b0;
            i_kind       <= 2'($urandom);
            i_block_byte <= 8'($urandom);
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= k;
        i_block_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        if (decode_request(k, b, r0, r1)) begin
            if (typed) begin
                r0 = '{lo_pcm, 1'b0, 1'b0, END_CONTINUE};
                r1 = '{hi_pcm, 1'b0, 1'b0, END_CONTINUE};
            end
            pending_pcm.push_back(r0);
            pending_pcm.push_back(r1);
        end
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pcm.size() != 0)
            @(posedge i_clk);
        // header, flags and restart leave no result to wait on
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_output_enable(input logic v);
        wait_drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        out_enable = v;
    endtask

    task automatic send_block(input bit noisy);
        int         n_data;
        logic [3:0] filt_nib;
        logic [7:0] flag_byte;
        if ($urandom_range(99) < 8)
            issue_request(KIND_RESTART, 8'($urandom));
        filt_nib = ($urandom_range(99) < 85) ? 4'($urandom_range(4))
                                             : 4'($urandom_range(15, 5));
        issue_request(KIND_HEADER, {filt_nib, 4'($urandom)});
        case ($urandom_range(3))
            0:       flag_byte = 8'($urandom);
            1:       flag_byte = 8'h03;
            default: flag_byte = 8'($urandom_range(7));
        endcase
        issue_request(KIND_FLAGS, flag_byte);
        // noisy blocks stop short or run past the end of the block
        n_data = noisy ? $urandom_range(22, 1) : int'(BLOCK_DATA_BYTES);
        repeat (n_data)
            issue_request(KIND_DATA, 8'($urandom));
    endtask

    initial begin : rx_stall_gen
        @(posedge i_clk);
        forever begin
            if (hold_reqs != holds_done) begin
                holds_done++;
                repeat (HOLD_CYCLES) begin
                    i_out_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_pcm_result exp_pcm;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pcm.size() == 0) begin
                $display("%0t: sample exp none got %0d", $time, o_sample);
                mismatch_count++;
            end else begin
                exp_pcm = pending_pcm.pop_front();
                if (o_sample !== exp_pcm.sample) begin
                    $display("%0t: sample exp %0d got %0d", $time, exp_pcm.sample, o_sample);
                    mismatch_count++;
                end
                if (o_block_last !== exp_pcm.last) begin
                    $display("%0t: block_last exp %0d got %0d",
                             $time, exp_pcm.last, o_block_last);
                    mismatch_count++;
                end
                if (o_loop_mark !== exp_pcm.loop_mark) begin
                    $display("%0t: loop_mark exp %0d got %0d",
                             $time, exp_pcm.loop_mark, o_loop_mark);
                    mismatch_count++;
                end
                if (o_end_action !== exp_pcm.act) begin
                    $display("%0t: end_action exp %0d got %0d",
                             $time, exp_pcm.act, o_end_action);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        int          r;
        int unsigned phase_end;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg_before)
                write_output_enable(dir_rows[i].cfg_val);
            repeat (dir_rows[i].reps)
                issue_request(dir_rows[i].kind, dir_rows[i].data, dir_rows[i].typed,
                              dir_rows[i].lo_pcm, dir_rows[i].hi_pcm);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_output_enable(phase_enable[p] != 0);
            send_idle_pct = phase_idle[p];
            stall_pct     = phase_stall[p];
            // long receiver hold-off so the decoder backs up into its input
            if (p == 3)
                hold_reqs <= hold_reqs + 1;
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                r = $urandom_range(99);
                if (r < 10)
                    repeat ($urandom_range(4, 1))
                        issue_request(t_kind'(2'($urandom)), 8'($urandom));
                else
                    send_block(r < 22);
            end
        end

        wait_drain();
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
